FILE: hdl/http_header_line_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the header line parser checker
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_UNIT_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_UNIT_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define HHLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HHLP_ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// types and codes shared by the header line parser files
// ----------------------------------------------------------------------------
`default_nettype none

package hhlp_pkg;

	localparam int unsigned LEN_W = 10;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd255;

	// parse phases
	localparam logic [3:0] PH_START = 4'd0;
	localparam logic [3:0] PH_NAME  = 4'd1;
	localparam logic [3:0] PH_COLON = 4'd2;
	localparam logic [3:0] PH_SPACE = 4'd3;
	localparam logic [3:0] PH_VALUE = 4'd4;
	localparam logic [3:0] PH_CR    = 4'd5;
	localparam logic [3:0] PH_LF    = 4'd6;
	localparam logic [3:0] PH_ENDCR = 4'd7;
	localparam logic [3:0] PH_DONE  = 4'd8;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] ROLE_SKIP  = 3'd0;
	localparam logic [2:0] ROLE_NAME  = 3'd1;
	localparam logic [2:0] ROLE_SEP   = 3'd2;
	localparam logic [2:0] ROLE_VALUE = 3'd3;
	localparam logic [2:0] ROLE_EOL   = 3'd4;
	localparam logic [2:0] ROLE_EOB   = 3'd5;
	localparam logic [2:0] ROLE_BODY  = 3'd6;

	localparam logic [1:0] STAT_BUSY  = 2'd0;
	localparam logic [1:0] STAT_DONE  = 2'd1;
	localparam logic [1:0] STAT_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NAME_EOL  = 3'd1;
	localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
	localparam logic [2:0] ERR_VALUE_LEN = 3'd3;
	localparam logic [2:0] ERR_CR_NO_LF  = 3'd4;
	localparam logic [2:0] ERR_END_NO_LF = 3'd5;

	typedef struct packed {
		logic [3:0]       phase;
		logic [LEN_W-1:0] offset;
		logic [2:0]       err;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_START, offset: '0, err: ERR_NONE};

	typedef struct packed {
		logic [2:0] role;
		logic       pair_done;
		logic [1:0] status;
		logic [2:0] error_cause;
	} byte_result_t;

endpackage

`default_nettype wire

FILE: hdl/hhlp_in_if.sv
// ----------------------------------------------------------------------------
// hhlp_in_if
// input channel of the header line parser: one stream byte per item
// ----------------------------------------------------------------------------
`default_nettype none

interface hhlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       restart;

	modport source (output valid, output byte_in, output restart, input ready);
	modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

`default_nettype wire

FILE: hdl/hhlp_out_if.sv
// ----------------------------------------------------------------------------
// hhlp_out_if
// result channel of the header line parser: one tagged byte per item
// ----------------------------------------------------------------------------
`default_nettype none

interface hhlp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] role;
	logic       pair_done;
	logic [1:0] status;
	logic [2:0] error_cause;

	modport source (output valid, output byte_out, output role, output pair_done,
		output status, output error_cause, input ready);
	modport sink   (input valid, input byte_out, input role, input pair_done,
		input status, input error_cause, output ready);
endinterface

`default_nettype wire

FILE: hdl/hhlp_step.sv
// ----------------------------------------------------------------------------
// hhlp_step
// next-state and byte classification for one header byte
// ----------------------------------------------------------------------------
`default_nettype none

module hhlp_step (
	input  hhlp_pkg::parse_state_t     cur,
	input  logic [7:0]                 byte_in,
	input  logic                       restart,
	input  logic [hhlp_pkg::LEN_W-1:0] max_len,
	output hhlp_pkg::parse_state_t     nxt,
	output hhlp_pkg::byte_result_t     res
);

	hhlp_pkg::parse_state_t st;
	logic [2:0]             fail;
	logic [2:0]             role;
	logic                   pair;
	logic [1:0]             stat;
	logic [hhlp_pkg::LEN_W:0] off_inc;

	assign off_inc = {1'b0, st.offset} + {{hhlp_pkg::LEN_W{1'b0}}, 1'b1};

	always_comb begin
		st   = restart ? hhlp_pkg::STATE_RESET : cur;
		nxt  = st;
		role = hhlp_pkg::ROLE_SKIP;
		pair = 1'b0;
		stat = hhlp_pkg::STAT_BUSY;
		fail = hhlp_pkg::ERR_NONE;

		if (st.err == hhlp_pkg::ERR_NONE) begin
			case (st.phase)
				hhlp_pkg::PH_NAME: begin
					if (byte_in == hhlp_pkg::CH_COLON) begin
						nxt.phase = hhlp_pkg::PH_COLON;
						role      = hhlp_pkg::ROLE_SEP;
					end else if (byte_in inside {hhlp_pkg::CH_CR, hhlp_pkg::CH_LF}) begin
						fail = hhlp_pkg::ERR_NAME_EOL;
					end else begin
						role = hhlp_pkg::ROLE_NAME;
					end
				end
				hhlp_pkg::PH_COLON: begin
					if (byte_in == hhlp_pkg::CH_SPACE) begin
						nxt.phase = hhlp_pkg::PH_SPACE;
						role      = hhlp_pkg::ROLE_SEP;
					end else begin
						fail = hhlp_pkg::ERR_NO_SPACE;
					end
				end
				hhlp_pkg::PH_SPACE: begin
					// first value byte is taken whatever it is
					nxt.phase  = hhlp_pkg::PH_VALUE;
					nxt.offset = '0;
					role       = hhlp_pkg::ROLE_VALUE;
				end
				hhlp_pkg::PH_VALUE: begin
					if (byte_in == hhlp_pkg::CH_CR) begin
						nxt.phase = hhlp_pkg::PH_CR;
						role      = hhlp_pkg::ROLE_EOL;
					end else if (off_inc > {1'b0, max_len}) begin
						fail = hhlp_pkg::ERR_VALUE_LEN;
					end else begin
						nxt.offset = off_inc[hhlp_pkg::LEN_W-1:0];
						role       = hhlp_pkg::ROLE_VALUE;
					end
				end
				hhlp_pkg::PH_CR: begin
					if (byte_in == hhlp_pkg::CH_LF) begin
						nxt.phase = hhlp_pkg::PH_LF;
						role      = hhlp_pkg::ROLE_EOL;
						pair      = 1'b1;
					end else begin
						fail = hhlp_pkg::ERR_CR_NO_LF;
					end
				end
				hhlp_pkg::PH_LF: begin
					if (byte_in == hhlp_pkg::CH_CR) begin
						nxt.phase = hhlp_pkg::PH_ENDCR;
						role      = hhlp_pkg::ROLE_EOB;
					end else begin
						nxt.phase = hhlp_pkg::PH_NAME;
						role      = hhlp_pkg::ROLE_NAME;
					end
				end
				hhlp_pkg::PH_ENDCR: begin
					if (byte_in == hhlp_pkg::CH_LF) begin
						nxt.phase = hhlp_pkg::PH_DONE;
						role      = hhlp_pkg::ROLE_EOB;
						stat      = hhlp_pkg::STAT_DONE;
					end else begin
						fail = hhlp_pkg::ERR_END_NO_LF;
					end
				end
				hhlp_pkg::PH_DONE: begin
					role = hhlp_pkg::ROLE_BODY;
					stat = hhlp_pkg::STAT_DONE;
				end
				default: begin
					// start phase, and unused codes behave the same
					if (byte_in inside {hhlp_pkg::CH_CR, hhlp_pkg::CH_LF}) begin
						nxt.phase = hhlp_pkg::PH_START;
					end else begin
						nxt.phase = hhlp_pkg::PH_NAME;
						role      = hhlp_pkg::ROLE_NAME;
					end
				end
			endcase

			if (fail != hhlp_pkg::ERR_NONE) begin
				nxt.err = fail;
			end
		end

		if (nxt.err != hhlp_pkg::ERR_NONE) begin
			role = hhlp_pkg::ROLE_SKIP;
			pair = 1'b0;
			stat = hhlp_pkg::STAT_ERROR;
		end

		res.role        = role;
		res.pair_done   = pair;
		res.status      = stat;
		res.error_cause = nxt.err;
	end

endmodule

`default_nettype wire

FILE: hdl/http_header_line_parser_unit.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_unit
// byte-wide http header block parser: tags each byte with its role
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  in_ch    in   byte_in, restart                                 valid/ready
//  out_ch   out  byte_out, role, pair_done, status, error_cause   valid/ready
//  cfg      in   cfg_data (max value length - 1)                  cfg_we only
//
//  one item per cycle unless out_ch stalls; a byte's result appears the cycle
//  after it is taken, from a single output register behind the state update
//  in_ch.ready is high while the output register is empty or being emptied
//  arst_n clears the parse state, the output valid and the length register
//  (255); no result is lost or repeated across stalls on either side
// ----------------------------------------------------------------------------
`default_nettype none

module http_header_line_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	hhlp_in_if.sink                    in_ch,
	hhlp_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [hhlp_pkg::LEN_W-1:0] cfg_data
);

	hhlp_pkg::parse_state_t     state_q;
	hhlp_pkg::parse_state_t     state_nxt;
	hhlp_pkg::byte_result_t     res_nxt;
	hhlp_pkg::byte_result_t     res_q;
	logic [hhlp_pkg::LEN_W-1:0] max_len_q;
	logic [7:0]                 byte_q;
	logic                       out_valid_q;
	logic                       in_take;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_take     = in_ch.valid && in_ch.ready;

	hhlp_step u_step (
		.cur     (state_q),
		.byte_in (in_ch.byte_in),
		.restart (in_ch.restart),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hhlp_pkg::STATE_RESET;
			max_len_q   <= hhlp_pkg::MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (in_take) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each taken item
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_q <= in_ch.byte_in;
			res_q  <= res_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.byte_out    = byte_q;
	assign out_ch.role        = res_q.role;
	assign out_ch.pair_done   = res_q.pair_done;
	assign out_ch.status      = res_q.status;
	assign out_ch.error_cause = res_q.error_cause;

endmodule

`default_nettype wire

FILE: hdl/hhlp_checker.sv
// ----------------------------------------------------------------------------
// hhlp_checker
// port-level checks on the header line parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_header_line_parser_unit_assert.svh"

module hhlp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [2:0] out_role,
	input logic       out_pair,
	input logic [1:0] out_status,
	input logic [2:0] out_cause
);

	logic in_take;
	logic out_stall;
	logic out_err;
	logic out_cause_set;
	logic out_no_role;
	logic out_eol_busy;

	assign in_take       = in_valid && in_ready;
	assign out_stall     = out_valid && !out_ready;
	assign out_err       = (out_status == hhlp_pkg::STAT_ERROR);
	assign out_cause_set = (out_cause != hhlp_pkg::ERR_NONE);
	assign out_no_role   = (out_role == hhlp_pkg::ROLE_SKIP) && !out_pair;
	assign out_eol_busy  = (out_role == hhlp_pkg::ROLE_EOL) && (out_status == hhlp_pkg::STAT_BUSY);

	// a stalled result keeps its byte
	`HHLP_ASSERT(a_out_hold, clk, arst_n,
		out_stall |=> out_valid && $stable(out_byte), "stalled result changed")

	// every taken item shows up next cycle with its byte echoed
	`HHLP_ASSERT(a_echo, clk, arst_n,
		in_take |=> out_valid && (out_byte == $past(in_byte)), "taken byte not echoed")

	// error results carry a cause and no role; others carry no cause
	`HHLP_ASSERT(a_err_fields, clk, arst_n,
		out_valid |-> (out_err == out_cause_set) && (!out_err || out_no_role),
		"error fields inconsistent")

	// pair completion only on a line end while still in progress
	`HHLP_ASSERT(a_pair_eol, clk, arst_n,
		out_valid && out_pair |-> out_eol_busy, "pair_done off a line end")

	// nothing offered while in reset
	`HHLP_ASSERT_ANY(a_rst_idle, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind http_header_line_parser_unit hhlp_checker u_hhlp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_byte    (in_ch.byte_in),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_byte   (out_ch.byte_out),
	.out_role   (out_ch.role),
	.out_pair   (out_ch.pair_done),
	.out_status (out_ch.status),
	.out_cause  (out_ch.error_cause)
);

`default_nettype wire

FILE: tb/sv/http_header_line_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_line_parser_unit_test
// self-checking bench for the header line parser: a short scripted stream,
// then random header blocks under several length limits and stall patterns,
// each result checked against a scripted tag or a byte-level tagging model
// ----------------------------------------------------------------------------

module http_header_line_parser_unit_test;

	localparam int STALL_LIMIT = 1000;
	localparam int ITEMS_PER_PHASE = 265;
	localparam int SCRIPT_LEN = 25;

	typedef struct packed {
		logic [7:0]             data;
		hhlp_pkg::byte_result_t res;
	} tagged_byte_t;

	typedef struct packed {
		logic [7:0]             data;
		logic                   rs;
		logic                   typed;
		hhlp_pkg::byte_result_t res;
	} stim_row_t;

	localparam hhlp_pkg::byte_result_t NO_TAG = '0;
	localparam hhlp_pkg::byte_result_t TAG_SKIP =
		'{hhlp_pkg::ROLE_SKIP, 1'b0, hhlp_pkg::STAT_BUSY, hhlp_pkg::ERR_NONE};
	localparam hhlp_pkg::byte_result_t TAG_NAME =
		'{hhlp_pkg::ROLE_NAME, 1'b0, hhlp_pkg::STAT_BUSY, hhlp_pkg::ERR_NONE};
	localparam hhlp_pkg::byte_result_t TAG_VALUE =
		'{hhlp_pkg::ROLE_VALUE, 1'b0, hhlp_pkg::STAT_BUSY, hhlp_pkg::ERR_NONE};
	localparam hhlp_pkg::byte_result_t TAG_NO_SPACE =
		'{hhlp_pkg::ROLE_SKIP, 1'b0, hhlp_pkg::STAT_ERROR, hhlp_pkg::ERR_NO_SPACE};
	localparam hhlp_pkg::byte_result_t TAG_NAME_EOL =
		'{hhlp_pkg::ROLE_SKIP, 1'b0, hhlp_pkg::STAT_ERROR, hhlp_pkg::ERR_NAME_EOL};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [hhlp_pkg::LEN_W-1:0] cfg_data;

	hhlp_in_if  in_ch();
	hhlp_out_if out_ch();

	// typed expectation travelling with the item on the bus
	logic                   row_typed;
	hhlp_pkg::byte_result_t row_tag;

	// parser model state
	logic [3:0]                 parse_ph;
	logic [hhlp_pkg::LEN_W-1:0] val_off;
	logic [2:0]                 held_err;
	logic [hhlp_pkg::LEN_W-1:0] len_limit;

	tagged_byte_t pending_tags[$];
	stim_row_t    script [SCRIPT_LEN];
	int           mismatches;
	int           stall_cycles;
	int           src_idle_pct;
	int           rcv_idle_pct;

	http_header_line_parser_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic tagged_byte_t tag_byte(input logic [7:0] b, input logic rs);
		tagged_byte_t t;
		logic [2:0]   fail;
		t.data = b;
		t.res = TAG_SKIP;
		fail = hhlp_pkg::ERR_NONE;
		if (rs) begin
			parse_ph = hhlp_pkg::PH_START;
			val_off = '0;
			held_err = hhlp_pkg::ERR_NONE;
		end
		if (held_err == hhlp_pkg::ERR_NONE) begin
			case (parse_ph)
				hhlp_pkg::PH_NAME: begin
					if (b == hhlp_pkg::CH_COLON) begin
						parse_ph = hhlp_pkg::PH_COLON;
						t.res.role = hhlp_pkg::ROLE_SEP;
					end else if (b == hhlp_pkg::CH_CR || b == hhlp_pkg::CH_LF) begin
						fail = hhlp_pkg::ERR_NAME_EOL;
					end else begin
						t.res.role = hhlp_pkg::ROLE_NAME;
					end
				end
				hhlp_pkg::PH_COLON: begin
					if (b == hhlp_pkg::CH_SPACE) begin
						parse_ph = hhlp_pkg::PH_SPACE;
						t.res.role = hhlp_pkg::ROLE_SEP;
					end else begin
						fail = hhlp_pkg::ERR_NO_SPACE;
					end
				end
				hhlp_pkg::PH_SPACE: begin
					parse_ph = hhlp_pkg::PH_VALUE;
					val_off = '0;
					t.res.role = hhlp_pkg::ROLE_VALUE;
				end
				hhlp_pkg::PH_VALUE: begin
					if (b == hhlp_pkg::CH_CR) begin
						parse_ph = hhlp_pkg::PH_CR;
						t.res.role = hhlp_pkg::ROLE_EOL;
					end else if (int'(val_off) + 1 > int'(len_limit)) begin
						fail = hhlp_pkg::ERR_VALUE_LEN;
					end else begin
						val_off = val_off + 1'b1;
						t.res.role = hhlp_pkg::ROLE_VALUE;
					end
				end
				hhlp_pkg::PH_CR: begin
					if (b == hhlp_pkg::CH_LF) begin
						parse_ph = hhlp_pkg::PH_LF;
						t.res.role = hhlp_pkg::ROLE_EOL;
						t.res.pair_done = 1'b1;
					end else begin
						fail = hhlp_pkg::ERR_CR_NO_LF;
					end
				end
				hhlp_pkg::PH_LF: begin
					if (b == hhlp_pkg::CH_CR) begin
						parse_ph = hhlp_pkg::PH_ENDCR;
						t.res.role = hhlp_pkg::ROLE_EOB;
					end else begin
						parse_ph = hhlp_pkg::PH_NAME;
						t.res.role = hhlp_pkg::ROLE_NAME;
					end
				end
				hhlp_pkg::PH_ENDCR: begin
					if (b == hhlp_pkg::CH_LF) begin
						parse_ph = hhlp_pkg::PH_DONE;
						t.res.role = hhlp_pkg::ROLE_EOB;
						t.res.status = hhlp_pkg::STAT_DONE;
					end else begin
						fail = hhlp_pkg::ERR_END_NO_LF;
					end
				end
				hhlp_pkg::PH_DONE: begin
					t.res.role = hhlp_pkg::ROLE_BODY;
					t.res.status = hhlp_pkg::STAT_DONE;
				end
				default: begin
					// start phase and unused codes: line breaks are skipped
					if (b == hhlp_pkg::CH_CR || b == hhlp_pkg::CH_LF) begin
						parse_ph = hhlp_pkg::PH_START;
					end else begin
						parse_ph = hhlp_pkg::PH_NAME;
						t.res.role = hhlp_pkg::ROLE_NAME;
					end
				end
			endcase
			if (fail != hhlp_pkg::ERR_NONE)
				held_err = fail;
		end
		if (held_err != hhlp_pkg::ERR_NONE) begin
			t.res.role = hhlp_pkg::ROLE_SKIP;
			t.res.pair_done = 1'b0;
			t.res.status = hhlp_pkg::STAT_ERROR;
		end
		t.res.error_cause = held_err;
		return t;
	endfunction

	task automatic flag_mismatch(input string why, input tagged_byte_t want,
		input tagged_byte_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected byte %h role %0d pair %0b status %0d cause %0d",
				$realtime, why, want.data, want.res.role, want.res.pair_done,
				want.res.status, want.res.error_cause,
				"; got byte %h role %0d pair %0b status %0d cause %0d",
				got.data, got.res.role, got.res.pair_done, got.res.status,
				got.res.error_cause);
	endtask

	// results are checked before the item of the same edge is predicted
	always @(posedge clk) begin
		tagged_byte_t got;
		tagged_byte_t want;
		if (arst_n) begin
			if (cfg_we)
				len_limit = cfg_data;
			if (out_ch.valid && out_ch.ready) begin
				got.data = out_ch.byte_out;
				got.res = '{out_ch.role, out_ch.pair_done, out_ch.status, out_ch.error_cause};
				if (pending_tags.size() == 0) begin
					flag_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_tags.pop_front();
					if (got.data !== want.data || got.res.role !== want.res.role ||
						got.res.pair_done !== want.res.pair_done ||
						got.res.status !== want.res.status ||
						got.res.error_cause !== want.res.error_cause)
						flag_mismatch("mismatch", want, got);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = tag_byte(in_ch.byte_in, in_ch.restart);
				if (row_typed)
					want.res = row_tag;
				pending_tags.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		out_ch.ready <= (rcv_idle_pct == 0) || ($urandom_range(99, 0) >= rcv_idle_pct);

	task automatic send_byte(input logic [7:0] b, input logic rs, input logic typed,
		input hhlp_pkg::byte_result_t tag);
		while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= b;
		in_ch.restart <= rs;
		row_typed <= typed;
		row_tag <= tag;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		@(posedge clk);
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_len(input logic [hhlp_pkg::LEN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte(input bit no_lf, input bit no_colon);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255, 0));
		while (b == hhlp_pkg::CH_CR || (no_lf && b == hhlp_pkg::CH_LF) ||
			(no_colon && b == hhlp_pkg::CH_COLON));
		return b;
	endfunction

	// one header block: optional leading line breaks, a few pairs, the end
	// marker and some body; now and then one byte is damaged or dropped
	task automatic send_block(input bit hold, inout int sent);
		logic [7:0] blk[$];
		int         lines;
		int         vlen;
		int         pos;
		logic       first_rs;
		blk = {};
		if (hold) begin
			in_ch.valid <= 1'b0;
			settle();
		end
		repeat ($urandom_range(2, 0))
			blk.push_back($urandom_range(1, 0) ? hhlp_pkg::CH_CR : hhlp_pkg::CH_LF);
		lines = $urandom_range(4, 1);
		for (int ln = 0; ln < lines; ln++) begin
			if ($urandom_range(5, 0) == 0)
				blk.push_back((ln != 0 && $urandom_range(1, 0)) ?
					hhlp_pkg::CH_LF : hhlp_pkg::CH_COLON);
			else
				blk.push_back(pick_byte(ln == 0, 1'b1));
			repeat ($urandom_range(5, 0))
				blk.push_back(pick_byte(1'b1, 1'b1));
			blk.push_back(hhlp_pkg::CH_COLON);
			blk.push_back(hhlp_pkg::CH_SPACE);
			if (len_limit < 40 && $urandom_range(3, 0) == 0)
				vlen = int'(len_limit) + 1 + $urandom_range(1, 0);
			else
				vlen = $urandom_range(6, 1);
			blk.push_back(($urandom_range(7, 0) == 0) ?
				hhlp_pkg::CH_CR : 8'($urandom_range(255, 0)));
			repeat (vlen - 1)
				blk.push_back(pick_byte(1'b0, 1'b0));
			blk.push_back(hhlp_pkg::CH_CR);
			blk.push_back(hhlp_pkg::CH_LF);
		end
		blk.push_back(hhlp_pkg::CH_CR);
		blk.push_back(hhlp_pkg::CH_LF);
		repeat ($urandom_range(3, 0))
			blk.push_back(8'($urandom_range(255, 0)));
		if ($urandom_range(99, 0) < 20) begin
			pos = $urandom_range(blk.size() - 1, 0);
			case ($urandom_range(5, 0))
				0: blk[pos] = hhlp_pkg::CH_CR;
				1: blk[pos] = hhlp_pkg::CH_LF;
				2: blk[pos] = hhlp_pkg::CH_COLON;
				3: blk[pos] = hhlp_pkg::CH_SPACE;
				4: blk[pos] = 8'($urandom_range(255, 0));
				default: blk.delete(pos);
			endcase
		end
		first_rs = ($urandom_range(9, 0) != 0);
		foreach (blk[k])
			send_byte(blk[k], (k == 0) ? first_rs : ($urandom_range(199, 0) == 0),
				1'b0, NO_TAG);
		sent += blk.size();
	endtask

	task automatic send_noise(inout int sent);
		int n;
		n = $urandom_range(8, 1);
		repeat (n)
			send_byte(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0, 1'b0, NO_TAG);
		sent += n;
	endtask

	initial begin
		logic [hhlp_pkg::LEN_W-1:0] len_plan [6];
		int                         sent;
		int                         blocks;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.byte_in = '0;
		in_ch.restart = 1'b0;
		out_ch.ready = 1'b0;
		row_typed = 1'b0;
		row_tag = NO_TAG;
		parse_ph = hhlp_pkg::PH_START;
		val_off = '0;
		held_err = hhlp_pkg::ERR_NONE;
		len_limit = hhlp_pkg::MAX_LEN_RESET;
		mismatches = 0;
		stall_cycles = 0;
		src_idle_pct = 12;
		rcv_idle_pct = 52;

		script = '{
			'{hhlp_pkg::CH_CR,    1'b1, 1'b1, TAG_SKIP},      // leading line breaks skipped
			'{hhlp_pkg::CH_LF,    1'b0, 1'b1, TAG_SKIP},
			'{8'hFF,              1'b0, 1'b1, TAG_NAME},
			'{hhlp_pkg::CH_COLON, 1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_SPACE, 1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b0, NO_TAG},        // value may start with cr
			'{8'h00,              1'b0, 1'b1, TAG_VALUE},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_LF,    1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_LF,    1'b0, 1'b0, NO_TAG},        // lf opens the next name
			'{hhlp_pkg::CH_COLON, 1'b0, 1'b0, NO_TAG},
			'{"x",                1'b0, 1'b1, TAG_NO_SPACE},
			'{"y",                1'b0, 1'b1, TAG_NO_SPACE},  // error held
			'{"A",                1'b1, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b1, TAG_NAME_EOL},
			'{hhlp_pkg::CH_COLON, 1'b1, 1'b0, NO_TAG},        // colon as first name byte
			'{hhlp_pkg::CH_COLON, 1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_SPACE, 1'b0, 1'b0, NO_TAG},
			'{"v",                1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_LF,    1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_LF,    1'b0, 1'b0, NO_TAG},
			'{8'h80,              1'b0, 1'b0, NO_TAG},
			'{hhlp_pkg::CH_CR,    1'b0, 1'b0, NO_TAG}         // body keeps going
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_byte(script[i].data, script[i].rs, script[i].typed, script[i].res);
		in_ch.valid <= 1'b0;
		settle();

		len_plan = '{10'd0, 10'd1023, 10'd1, 10'($urandom_range(30, 2)),
			10'($urandom_range(1023, 1)), hhlp_pkg::MAX_LEN_RESET};
		for (int p = 0; p < 6; p++) begin
			src_idle_pct = (p < 2) ? 12 : (p < 4) ? 52 : 0;
			rcv_idle_pct = (p < 2) ? 52 : (p < 4) ? 12 : 0;
			write_len(len_plan[p]);
			sent = 0;
			blocks = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(9, 0) == 0)
					send_noise(sent);
				else
					send_block(blocks == 20 || $urandom_range(49, 0) == 0, sent);
				blocks++;
			end
			in_ch.valid <= 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: http_header_line_parser_unit.f
+incdir+hdl
hdl/hhlp_pkg.sv
hdl/hhlp_in_if.sv
hdl/hhlp_out_if.sv
hdl/hhlp_step.sv
hdl/http_header_line_parser_unit.sv
hdl/hhlp_checker.sv
tb/sv/http_header_line_parser_unit_test.sv
